// ===== hw/rtl/dpd_pkg.sv =====
// Shared types and constants for the debug packet deframer.
package dpd_pkg;

  localparam int unsigned MaxPayloadDefault = 16384;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CH_NAK   = 8'h2D;  // '-'

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [14:0] length;
    logic [7:0]  calc_sum;
    logic [7:0]  recv_sum;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

endpackage

// ===== hw/rtl/dpd_front.sv =====
// Front end: frame tracking, payload sum and checksum digit decode.
module dpd_front #(
  parameter int unsigned MAX_PAYLOAD = dpd_pkg::MaxPayloadDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    rx_byte,
  input  logic          q_full,
  output dpd_pkg::push_t q_push
);
  import dpd_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_DATA = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_LOW  = 4'b1000
  } phase_t;

  localparam logic [14:0] MaxCount = 15'(MAX_PAYLOAD);

  phase_t      phase, phase_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [14:0] payload_count, payload_count_next;
  logic [3:0]  high_digit, high_digit_next;
  logic [7:0]  sum_inc;
  logic [14:0] count_inc;
  logic [3:0]  digit;
  logic [7:0]  recv;
  logic        accept;

  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) v = 4'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h46) v = 4'(ch - 8'h37);
    else if (ch >= 8'h61 && ch <= 8'h66) v = 4'(ch - 8'h57);
    return v;
  endfunction

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign sum_inc   = 8'(running_sum + rx_byte);
  assign count_inc = 15'(payload_count + 15'd1);
  assign digit     = hex_value(rx_byte);
  assign recv      = {high_digit, digit};

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    payload_count_next = payload_count;
    high_digit_next    = high_digit;
    q_push             = '0;
    q_push.res.kind    = KIND_DATA;
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == CH_START) begin
            phase_next         = PH_DATA;
            running_sum_next   = '0;
            payload_count_next = '0;
            high_digit_next    = '0;
          end
        end
        PH_DATA: begin
          if (rx_byte == CH_END) begin
            phase_next = PH_HIGH;
          end else begin
            running_sum_next   = sum_inc;
            payload_count_next = count_inc;
            // full payload: digits follow with no end character
            if (count_inc >= MaxCount) phase_next = PH_HIGH;
            q_push.push     = 1'b1;
            q_push.res.data = rx_byte;
          end
        end
        PH_HIGH: begin
          high_digit_next = digit;
          phase_next      = PH_LOW;
        end
        PH_LOW: begin
          q_push.push            = 1'b1;
          q_push.res.kind        = (recv == running_sum) ? KIND_GOOD : KIND_BAD;
          q_push.res.data        = (recv == running_sum) ? CH_ACK : CH_NAK;
          q_push.res.length      = payload_count;
          q_push.res.calc_sum    = running_sum;
          q_push.res.recv_sum    = recv;
          phase_next             = PH_HUNT;
          running_sum_next       = '0;
          payload_count_next     = '0;
          high_digit_next        = '0;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      running_sum   <= '0;
      payload_count <= '0;
      high_digit    <= '0;
    end else begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      payload_count <= payload_count_next;
      high_digit    <= high_digit_next;
    end
  end

endmodule

// ===== hw/rtl/dpd_queue.sv =====
// Short result queue between the front end and the output stage.
module dpd_queue (
  input  logic            clk,
  input  logic            rst,
  input  dpd_pkg::push_t  q_push,
  output logic            q_full,
  output logic            q_valid,
  output dpd_pkg::result_t q_head,
  input  logic            q_pop
);
  import dpd_pkg::*;

  localparam int unsigned Depth = QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  result_t         entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign q_full  = (count == FullCnt);
  assign q_valid = (count != '0);
  assign q_head  = entries[rd_ptr];
  assign do_push = q_push.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= q_push.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : PtrW'(wr_ptr + 1'b1);
      if (do_pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : PtrW'(rd_ptr + 1'b1);
      unique case ({do_push, do_pop})
        2'b10:   count <= CntW'(count + 1'b1);
        2'b01:   count <= CntW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dpd_back.sv =====
// Output stage: registers one result and holds it until the transaction completes.
module dpd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  dpd_pkg::result_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [14:0]      packet_length,
  output logic [7:0]       calc_sum,
  output logic [7:0]       recv_sum
);
  import dpd_pkg::*;

  result_t held;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) held <= q_head;
  end

  assign out_kind      = held.kind;
  assign out_byte      = held.data;
  assign packet_length = held.length;
  assign calc_sum      = held.calc_sum;
  assign recv_sum      = held.recv_sum;

endmodule

// ===== hw/rtl/debug_packet_deframer.sv =====
// Top level of the debug packet deframer.
// Takes one received character per transaction and sustains one per clock
// while the result queue is not full. Characters before '$' are dropped;
// payload characters come out as kind 0, and after '#' (or once the payload
// reaches MAX_PAYLOAD bytes) two hex digits are decoded into a verdict of
// kind 1 ('+') or kind 2 ('-') carrying the packet length and both checksums.
// When its character is accepted, the front end writes a result into a
// two-entry queue; the output register takes it from the queue head once the
// output is free. The queue lets the input keep flowing for two results while
// the output is stalled; input ready drops when it is full.
module debug_packet_deframer #(
  parameter int unsigned MAX_PAYLOAD = dpd_pkg::MaxPayloadDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [14:0] packet_length,
  output logic [7:0]  calc_sum,
  output logic [7:0]  recv_sum
);
  import dpd_pkg::*;

  push_t   q_push;
  logic    q_full, q_valid, q_pop;
  result_t q_head;

  dpd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk, .rst, .in_valid, .in_ready, .rx_byte, .q_full, .q_push
  );

  dpd_queue u_queue (
    .clk, .rst, .q_push, .q_full, .q_valid, .q_head, .q_pop
  );

  dpd_back u_back (
    .clk, .rst, .q_valid, .q_head, .q_pop,
    .out_valid, .out_ready, .out_kind, .out_byte,
    .packet_length, .calc_sum, .recv_sum
  );

endmodule
